@@ hw/rtl/deque_with_value_delete_unit_defines.svh @@
// Assertion macros for the deque with delete-by-value unit.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef DEQUE_WITH_VALUE_DELETE_UNIT_DEFINES_SVH
`define DEQUE_WITH_VALUE_DELETE_UNIT_DEFINES_SVH

// Checks a property at every clock edge outside reset.
`define DQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks that a consequent holds in the cycle after its antecedent.
`define DQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/dq_pkg.sv @@
// Shared types, constants and index helpers for the deque unit.
// No dependencies; used by the controller and the top level.
package dq_pkg;

  localparam int CAPACITY = 32;
  localparam int DATA_W   = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam logic [2:0] KIND_PUSH_FRONT = 3'd0;
  localparam logic [2:0] KIND_PUSH_BACK  = 3'd1;
  localparam logic [2:0] KIND_POP_FRONT  = 3'd2;
  localparam logic [2:0] KIND_POP_BACK   = 3'd3;
  localparam logic [2:0] KIND_DELETE     = 3'd4;
  localparam logic [2:0] KIND_READ_FWD   = 3'd5;
  localparam logic [2:0] KIND_READ_BWD   = 3'd6;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  typedef struct packed {
    logic [2:0]               kind;
    logic signed [DATA_W-1:0] operand;
  } in_item_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [DATA_W-1:0] element;
    logic                     last;
  } out_item_t;

  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [DATA_W-1:0] wdata;
    logic              re;
    logic [IDX_W-1:0]  raddr;
  } ram_req_t;

  // Physical slot of a list position in the circular store.
  function automatic logic [IDX_W-1:0] phys_idx(input logic [IDX_W-1:0] base,
                                                input logic [CNT_W-1:0] offs);
    logic [CNT_W:0] sum;
    sum = (CNT_W + 1)'(base) + (CNT_W + 1)'(offs);
    if (sum >= (CNT_W + 1)'(CAPACITY)) begin
      sum = sum - (CNT_W + 1)'(CAPACITY);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

@@ hw/rtl/dq_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package dependency.
module dq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/dq_ctrl.sv @@
// Command sequencer for the deque unit: pointers, search, shift and readout.
// Depends on dq_pkg and the assertion macros; drives one dq_ram instance.
`include "deque_with_value_delete_unit_defines.svh"

module dq_ctrl
  import dq_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  in_item_t          cmd,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output out_item_t         rsp,
  output ram_req_t          ram_req,
  input  logic [DATA_W-1:0] ram_rdata
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SEARCH,
    S_SHIFT,
    S_RSTART,
    S_EMIT,
    S_STATUS
  } state_t;

  state_t           state;
  in_item_t         cur;
  logic [IDX_W-1:0] head;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] rix;
  logic [CNT_W-1:0] wix;
  logic             pend;
  logic             cmpv;
  logic [1:0]       st;

  logic             full;
  logic             empty;
  logic             slot_free;
  logic             rsp_load;
  logic             found;
  logic             last_el;
  logic             fwd;
  logic [IDX_W-1:0] head_dec;
  logic [CNT_W-1:0] rd_pos;

  assign full      = (count == CNT_W'(CAPACITY));
  assign empty     = (count == '0);
  assign slot_free = !rsp_valid || rsp_ready;
  assign rsp_load  = slot_free && (state == S_EMIT || state == S_STATUS);
  assign found     = cmpv && (ram_rdata == cur.operand);
  assign last_el   = (rix == count - CNT_W'(1));
  assign fwd       = (cur.kind == KIND_READ_FWD);
  assign head_dec  = (head == '0) ? IDX_W'(CAPACITY - 1) : head - IDX_W'(1);
  assign cmd_ready = (state == S_IDLE);

  always_comb begin
    if (state == S_RSTART) begin
      rd_pos = fwd ? '0 : count - CNT_W'(1);
    end else begin
      rd_pos = fwd ? rix + CNT_W'(1) : count - CNT_W'(2) - rix;
    end
  end

  always_comb begin
    ram_req       = '0;
    ram_req.wdata = cur.operand;
    unique case (state)
      S_EXEC: begin
        if (!full && cur.kind == KIND_PUSH_FRONT) begin
          ram_req.we    = 1'b1;
          ram_req.waddr = head_dec;
        end else if (!full && cur.kind == KIND_PUSH_BACK) begin
          ram_req.we    = 1'b1;
          ram_req.waddr = phys_idx(head, count);
        end
      end
      S_SEARCH: begin
        if (!found && rix != count) begin
          ram_req.re    = 1'b1;
          ram_req.raddr = phys_idx(head, rix);
        end
      end
      S_SHIFT: begin
        if (pend) begin
          ram_req.we    = 1'b1;
          ram_req.waddr = phys_idx(head, wix);
          ram_req.wdata = ram_rdata;
        end
        if (rix != count) begin
          ram_req.re    = 1'b1;
          ram_req.raddr = phys_idx(head, rix);
        end
      end
      S_RSTART: begin
        ram_req.re    = 1'b1;
        ram_req.raddr = phys_idx(head, rd_pos);
      end
      S_EMIT: begin
        if (slot_free && !last_el) begin
          ram_req.re    = 1'b1;
          ram_req.raddr = phys_idx(head, rd_pos);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      count     <= '0;
      rix       <= '0;
      wix       <= '0;
      pend      <= 1'b0;
      cmpv      <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            cur   <= cmd;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          unique case (cur.kind)
            KIND_PUSH_FRONT: begin
              state <= S_STATUS;
              if (full) begin
                st <= ST_FULL;
              end else begin
                st    <= ST_OK;
                head  <= head_dec;
                count <= count + CNT_W'(1);
              end
            end
            KIND_PUSH_BACK: begin
              state <= S_STATUS;
              if (full) begin
                st <= ST_FULL;
              end else begin
                st    <= ST_OK;
                count <= count + CNT_W'(1);
              end
            end
            KIND_POP_FRONT: begin
              state <= S_STATUS;
              if (empty) begin
                st <= ST_EMPTY;
              end else begin
                st    <= ST_OK;
                head  <= phys_idx(head, CNT_W'(1));
                count <= count - CNT_W'(1);
              end
            end
            KIND_POP_BACK: begin
              state <= S_STATUS;
              if (empty) begin
                st <= ST_EMPTY;
              end else begin
                st    <= ST_OK;
                count <= count - CNT_W'(1);
              end
            end
            KIND_DELETE: begin
              if (empty) begin
                st    <= ST_EMPTY;
                state <= S_STATUS;
              end else begin
                rix   <= '0;
                cmpv  <= 1'b0;
                state <= S_SEARCH;
              end
            end
            KIND_READ_FWD, KIND_READ_BWD: begin
              if (empty) begin
                st    <= ST_EMPTY;
                state <= S_STATUS;
              end else begin
                rix   <= '0;
                state <= S_RSTART;
              end
            end
            default: begin
              st    <= ST_OK;
              state <= S_STATUS;
            end
          endcase
        end
        S_SEARCH: begin
          if (found) begin
            wix   <= rix - CNT_W'(1);
            pend  <= 1'b0;
            state <= S_SHIFT;
          end else if (rix == count) begin
            st    <= ST_NOTFOUND;
            state <= S_STATUS;
          end else begin
            rix  <= rix + CNT_W'(1);
            cmpv <= 1'b1;
          end
        end
        S_SHIFT: begin
          if (pend) begin
            wix <= wix + CNT_W'(1);
          end
          if (rix != count) begin
            rix  <= rix + CNT_W'(1);
            pend <= 1'b1;
          end else begin
            pend <= 1'b0;
            if (!pend) begin
              count <= count - CNT_W'(1);
              st    <= ST_OK;
              state <= S_STATUS;
            end
          end
        end
        S_RSTART: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (slot_free) begin
            rsp.status  <= ST_OK;
            rsp.element <= ram_rdata;
            rsp.last    <= last_el;
            if (last_el) begin
              state <= S_IDLE;
            end else begin
              rix <= rix + CNT_W'(1);
            end
          end
        end
        S_STATUS: begin
          if (slot_free) begin
            rsp.status  <= st;
            rsp.element <= '0;
            rsp.last    <= 1'b1;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `DQ_ASSERT(a_count_bound, count <= CNT_W'(CAPACITY), "entry count exceeds capacity")
  `DQ_ASSERT_NEXT(a_busy_after_accept, cmd_valid && cmd_ready, !cmd_ready, "ready after accept")
  `DQ_ASSERT(a_write_phase, ram_req.we |-> (state == S_EXEC || state == S_SHIFT), "stray write")
  `DQ_ASSERT(a_count_step, (count != $past(count)) |-> ((count == $past(count) + CNT_W'(1)) || (count + CNT_W'(1) == $past(count))), "count jumped")

endmodule

@@ hw/rtl/deque_with_value_delete_unit.sv @@
// Deque with delete-by-value. One command is taken per transaction, only when idle; the unit
// is busy until its last result is in the output register.
// Push, pop and the unused command: the execute and then the status state, then the result is registered.
// Delete by value: the search and then the shift walk the list one entry a cycle.
// Readout: the execute and read-start states, then one element per cycle while the output slot is free.
// Synchronous reset empties the list at once; the entry RAM is not cleared.
module deque_with_value_delete_unit
  import dq_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  output logic      cmd_ready,
  input  in_item_t  cmd,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  output out_item_t rsp
);

  ram_req_t          ram_req;
  logic [DATA_W-1:0] ram_rdata;

  dq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata)
  );

  dq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

endmodule

@@ tb/sv/deque_checker.sv @@
`timescale 1ns / 1ps
// Checker for the deque with delete-by-value: it mirrors the list contents, predicts
// the responses of each accepted command and compares them with the unit's output.
// It depends on dq_pkg for the command, response and status definitions.
module deque_checker
  import dq_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  input  logic      cmd_ready,
  input  in_item_t  cmd,
  input  logic      rsp_valid,
  input  logic      rsp_ready,
  input  out_item_t rsp,
  output int        mismatches,
  output int        outstanding
);

  logic signed [DATA_W-1:0] list_mirror[$];
  out_item_t                due_rsp[$];
  int                       err_count = 0;

  function automatic out_item_t status_only(input logic [1:0] st);
    out_item_t r;
    r.status  = st;
    r.element = '0;
    r.last    = 1'b1;
    return r;
  endfunction

  task automatic apply_cmd(input in_item_t c);
    int        hit;
    int        n;
    int        pos;
    out_item_t r;
    n = list_mirror.size();
    case (c.kind)
      KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
        if (n >= CAPACITY) begin
          due_rsp.push_back(status_only(ST_FULL));
        end else begin
          if (c.kind == KIND_PUSH_FRONT) list_mirror.push_front(c.operand);
          else list_mirror.push_back(c.operand);
          due_rsp.push_back(status_only(ST_OK));
        end
      end
      KIND_POP_FRONT, KIND_POP_BACK: begin
        if (n == 0) begin
          due_rsp.push_back(status_only(ST_EMPTY));
        end else begin
          if (c.kind == KIND_POP_FRONT) void'(list_mirror.pop_front());
          else void'(list_mirror.pop_back());
          due_rsp.push_back(status_only(ST_OK));
        end
      end
      KIND_DELETE: begin
        if (n == 0) begin
          due_rsp.push_back(status_only(ST_EMPTY));
        end else begin
          hit = -1;
          for (int i = 0; i < n; i++) begin
            if (hit < 0 && list_mirror[i] == c.operand) hit = i;
          end
          if (hit < 0) begin
            due_rsp.push_back(status_only(ST_NOTFOUND));
          end else begin
            list_mirror.delete(hit);
            due_rsp.push_back(status_only(ST_OK));
          end
        end
      end
      KIND_READ_FWD, KIND_READ_BWD: begin
        if (n == 0) begin
          due_rsp.push_back(status_only(ST_EMPTY));
        end else begin
          for (int i = 0; i < n; i++) begin
            pos       = (c.kind == KIND_READ_FWD) ? i : n - 1 - i;
            r.status  = ST_OK;
            r.element = list_mirror[pos];
            r.last    = (i == n - 1);
            due_rsp.push_back(r);
          end
        end
      end
      default: begin
        due_rsp.push_back(status_only(ST_OK));
      end
    endcase
  endtask

  task automatic check_rsp(input out_item_t got);
    out_item_t want;
    if (due_rsp.size() == 0) begin
      err_count++;
      if (err_count <= 10) begin
        $display("%0t: response with none due: status=%0d element=%0d last=%0d",
                 $time, got.status, got.element, got.last);
      end
    end else begin
      want = due_rsp.pop_front();
      if (got.status !== want.status || got.element !== want.element ||
          got.last !== want.last) begin
        err_count++;
        if (err_count <= 10) begin
          $display("%0t: mismatch: want status=%0d element=%0d last=%0d, got status=%0d element=%0d last=%0d",
                   $time, want.status, want.element, want.last,
                   got.status, got.element, got.last);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      list_mirror.delete();
      due_rsp.delete();
    end else begin
      if (cmd_valid && cmd_ready) apply_cmd(cmd);
      if (rsp_valid && rsp_ready) check_rsp(rsp);
    end
    mismatches  <= err_count;
    outstanding <= due_rsp.size();
  end

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// Top of the deque testbench: clock, reset and command stimulus with random idling.
// It instantiates deque_with_value_delete_unit beside deque_checker and gives the verdict.
module tb_top;
  import dq_pkg::*;

  localparam logic [2:0]               KIND_NOP = 3'd7;
  localparam logic signed [DATA_W-1:0] VAL_MIN  = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] VAL_MAX  = 32'sh7fff_ffff;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      cmd_valid = 1'b0;
  logic      cmd_ready;
  in_item_t  cmd       = '0;
  logic      rsp_valid;
  logic      rsp_ready = 1'b0;
  out_item_t rsp;
  logic      steady    = 1'b0;
  int        mismatches;
  int        outstanding;

  deque_with_value_delete_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  deque_checker chk (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd_ready   (cmd_ready),
    .cmd         (cmd),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp_ready),
    .rsp         (rsp),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    rsp_ready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 27);
  end

  initial begin
    #5ms;
    $display("FAILURE");
    $finish;
  end

  task automatic send(input logic [2:0] cmd_kind, input logic signed [DATA_W-1:0] value);
    while (!steady && $urandom_range(0, 99) < 27) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd       <= '{kind: cmd_kind, operand: value};
    @(posedge clk);
    while (!cmd_ready) @(posedge clk);
  endtask

  // Values come mostly from a small pool so that deletes by value often find a match.
  function automatic logic signed [DATA_W-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 9);
    case (r)
      0:       return VAL_MIN;
      1:       return VAL_MAX;
      2, 3:    return $urandom;
      default: return $signed(32'($urandom_range(0, 7))) - 4;
    endcase
  endfunction

  task automatic run_phase(input int n, input int push_pct, input int pop_pct,
                           input int del_pct, input int read_pct);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < push_pct) begin
        send($urandom_range(0, 1) ? KIND_PUSH_FRONT : KIND_PUSH_BACK, pick_value());
      end else if (r < push_pct + pop_pct) begin
        send($urandom_range(0, 1) ? KIND_POP_FRONT : KIND_POP_BACK, $urandom);
      end else if (r < push_pct + pop_pct + del_pct) begin
        send(KIND_DELETE, pick_value());
      end else if (r < push_pct + pop_pct + del_pct + read_pct) begin
        send($urandom_range(0, 1) ? KIND_READ_FWD : KIND_READ_BWD, $urandom);
      end else begin
        send(KIND_NOP, $urandom);
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Every pop, delete and readout on the empty list, and the unused command.
    send(KIND_READ_FWD, 32'sd0);
    send(KIND_READ_BWD, VAL_MAX);
    send(KIND_POP_FRONT, VAL_MIN);
    send(KIND_POP_BACK, -32'sd1);
    send(KIND_DELETE, 32'sd0);
    send(KIND_NOP, -32'sd1);
    // Build a short list holding the extremes and a duplicate.
    send(KIND_PUSH_BACK, VAL_MAX);
    send(KIND_PUSH_FRONT, VAL_MIN);
    send(KIND_PUSH_BACK, -32'sd1);
    send(KIND_PUSH_FRONT, 32'sd0);
    send(KIND_PUSH_BACK, 32'sd5);
    send(KIND_PUSH_BACK, -32'sd1);
    send(KIND_READ_FWD, 32'sd0);
    send(KIND_READ_BWD, 32'sd0);
    // Only the first of two equal words goes; a missing value leaves the list alone.
    send(KIND_DELETE, -32'sd1);
    send(KIND_DELETE, 32'sd12345);
    send(KIND_READ_FWD, 32'sd0);
    send(KIND_POP_FRONT, 32'sd0);
    send(KIND_POP_BACK, 32'sd0);
    send(KIND_DELETE, VAL_MAX);
    send(KIND_READ_BWD, 32'sd0);
    send(KIND_POP_FRONT, 32'sd0);
    send(KIND_POP_BACK, 32'sd0);

    // Fill well past capacity, then a stretch with no idling, then drain.
    run_phase(42, 95, 1, 1, 3);
    steady <= 1'b1;
    run_phase(20, 35, 25, 20, 15);
    steady <= 1'b0;
    run_phase(15, 10, 50, 25, 12);

    cmd_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
